FILE: sv/assert_macros.svh
// Concurrent assertion helpers, sampled on clk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define PCE_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

`define PCE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/pce_pkg.sv
package pce_pkg;

	localparam int DEF_SAMPLE_BITS = 16;
	localparam int DEF_MAX_LEN     = 1024;
	localparam int QUEUE_DEPTH     = 2;

	localparam int CORR_W       = 16;
	localparam int PAIR_COUNT_W = 11;
	localparam int STATUS_W     = 2;

	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_ZERO_VAR = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_DROPPED  = 2'd2;

	localparam logic [CORR_W-1:0] CORR_MAX = 16'h7FFF;
	localparam logic [CORR_W-1:0] QUO_ONE  = 16'h8000;

	localparam logic [2:0] OP_N_SXX    = 3'd0;
	localparam logic [2:0] OP_SX_SX    = 3'd1;
	localparam logic [2:0] OP_N_SYY    = 3'd2;
	localparam logic [2:0] OP_SY_SY    = 3'd3;
	localparam logic [2:0] OP_N_SXY    = 3'd4;
	localparam logic [2:0] OP_SX_SY    = 3'd5;
	localparam logic [2:0] OP_VAR_PROD = 3'd6;

	localparam logic [2:0] STEP_LL = 3'd0;
	localparam logic [2:0] STEP_LH = 3'd1;
	localparam logic [2:0] STEP_HL = 3'd2;
	localparam logic [2:0] STEP_HH = 3'd3;
	localparam logic [2:0] STEP_WB = 3'd4;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL  = 5'b00010,
		ST_SQRT = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_DONE = 5'b10000
	} back_state_t;

	function automatic int count_w(input int max_len);
		return $clog2(max_len + 1);
	endfunction

	function automatic int sum_w(input int bits, input int max_len);
		return bits + count_w(max_len);
	endfunction

	function automatic int sq_w(input int bits, input int max_len);
		return 2 * bits - 2 + count_w(max_len);
	endfunction

	function automatic int cross_w(input int bits, input int max_len);
		return 2 * bits - 1 + count_w(max_len);
	endfunction

	function automatic int entry_w(input int bits, input int max_len);
		return count_w(max_len) + 1 + 2 * sum_w(bits, max_len) + 2 * sq_w(bits, max_len)
			+ cross_w(bits, max_len);
	endfunction

endpackage

FILE: sv/pce_front.sv
module pce_front
	import pce_pkg::*;
#(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	parameter int MAX_LEN     = DEF_MAX_LEN,
	parameter int EW          = entry_w(DEF_SAMPLE_BITS, DEF_MAX_LEN)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic signed [SAMPLE_BITS-1:0] x_sample,
	input  logic signed [SAMPLE_BITS-1:0] y_sample,
	input  logic                          last_sample,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	output logic                          q_push,
	output logic [EW-1:0]                 q_data,
	input  logic                          q_full
);

	localparam int CW  = count_w(MAX_LEN);
	localparam int SXW = sum_w(SAMPLE_BITS, MAX_LEN);
	localparam int SQW = sq_w(SAMPLE_BITS, MAX_LEN);
	localparam int SPW = cross_w(SAMPLE_BITS, MAX_LEN);
	localparam int PW  = 2 * SAMPLE_BITS;

	logic                    accept;
	logic                    kept;
	logic                    advance;
	logic signed [PW-1:0]    pxx;
	logic signed [PW-1:0]    pyy;
	logic signed [PW-1:0]    pxy;

	logic [CW-1:0]           count_q;
	logic                    ovf_q;

	logic                    valid_s1;
	logic                    last_s1;
	logic [CW-1:0]           n_s1;
	logic                    ovf_s1;
	logic signed [SXW-1:0]   px_s1;
	logic signed [SXW-1:0]   py_s1;
	logic [SQW-1:0]          pxx_s1;
	logic [SQW-1:0]          pyy_s1;
	logic signed [SPW-1:0]   pxy_s1;

	logic signed [SXW-1:0]   sx_q;
	logic signed [SXW-1:0]   sy_q;
	logic [SQW-1:0]          sxx_q;
	logic [SQW-1:0]          syy_q;
	logic signed [SPW-1:0]   sxy_q;

	logic signed [SXW-1:0]   sx_next;
	logic signed [SXW-1:0]   sy_next;
	logic [SQW-1:0]          sxx_next;
	logic [SQW-1:0]          syy_next;
	logic signed [SPW-1:0]   sxy_next;

	assign pxx = x_sample * x_sample;
	assign pyy = y_sample * y_sample;
	assign pxy = x_sample * y_sample;

	assign kept         = count_q < CW'(MAX_LEN);
	assign sample_stall = valid_s1 && last_s1 && q_full;
	assign accept       = sample_valid && !sample_stall;
	assign advance      = valid_s1 && !(last_s1 && q_full);

	assign sx_next  = sx_q + px_s1;
	assign sy_next  = sy_q + py_s1;
	assign sxx_next = sxx_q + pxx_s1;
	assign syy_next = syy_q + pyy_s1;
	assign sxy_next = sxy_q + pxy_s1;

	assign q_push = advance && last_s1;
	assign q_data = {n_s1, ovf_s1, sx_next, sy_next, sxx_next, syy_next, sxy_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			ovf_q    <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (!sample_stall) begin
				valid_s1 <= accept;
			end
			if (accept) begin
				if (last_sample) begin
					count_q <= '0;
					ovf_q   <= 1'b0;
				end else begin
					count_q <= count_q + {{(CW-1){1'b0}}, kept};
					ovf_q   <= ovf_q | !kept;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1 <= last_sample;
			n_s1    <= count_q + {{(CW-1){1'b0}}, kept};
			ovf_s1  <= ovf_q | !kept;
			px_s1   <= kept ? SXW'(x_sample) : '0;
			py_s1   <= kept ? SXW'(y_sample) : '0;
			pxx_s1  <= kept ? SQW'($unsigned(pxx)) : '0;
			pyy_s1  <= kept ? SQW'($unsigned(pyy)) : '0;
			pxy_s1  <= kept ? SPW'(pxy) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q  <= '0;
			sy_q  <= '0;
			sxx_q <= '0;
			syy_q <= '0;
			sxy_q <= '0;
		end else if (advance) begin
			if (last_s1) begin
				sx_q  <= '0;
				sy_q  <= '0;
				sxx_q <= '0;
				syy_q <= '0;
				sxy_q <= '0;
			end else begin
				sx_q  <= sx_next;
				sy_q  <= sy_next;
				sxx_q <= sxx_next;
				syy_q <= syy_next;
				sxy_q <= sxy_next;
			end
		end
	end

endmodule

FILE: sv/pce_fifo.sv
module pce_fifo
	import pce_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             not_empty,
	output logic             full
);

	localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTRW-1:0]  wr_ptr_q;
	logic [PTRW-1:0]  rd_ptr_q;
	logic [CNTW-1:0]  count_q;

	assign not_empty = count_q != '0;
	assign full      = count_q == CNTW'(DEPTH);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: sv/pce_back.sv
module pce_back
	import pce_pkg::*;
#(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	parameter int MAX_LEN     = DEF_MAX_LEN,
	parameter int EW          = entry_w(DEF_SAMPLE_BITS, DEF_MAX_LEN)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_valid,
	input  logic [EW-1:0]            q_data,
	output logic                     q_pop,
	output logic signed [CORR_W-1:0] corr_q15,
	output logic [PAIR_COUNT_W-1:0]  pair_count,
	output logic [STATUS_W-1:0]      status,
	output logic                     result_valid,
	input  logic                     result_stall
);

	localparam int CW  = count_w(MAX_LEN);
	localparam int SXW = sum_w(SAMPLE_BITS, MAX_LEN);
	localparam int SQW = sq_w(SAMPLE_BITS, MAX_LEN);
	localparam int SPW = cross_w(SAMPLE_BITS, MAX_LEN);

	localparam int O_SXY = 0;
	localparam int O_SYY = O_SXY + SPW;
	localparam int O_SXX = O_SYY + SQW;
	localparam int O_SY  = O_SXX + SQW;
	localparam int O_SX  = O_SY + SXW;
	localparam int O_OVF = O_SX + SXW;
	localparam int O_N   = O_OVF + 1;

	back_state_t              state_q;
	logic [2:0]               op_q;
	logic [2:0]               step_q;
	logic [5:0]               iter_q;
	logic [3:0]               div_cnt_q;

	logic [63:0]              n64_q;
	logic [63:0]              sx64_q;
	logic [63:0]              sy64_q;
	logic [63:0]              sxx64_q;
	logic [63:0]              syy64_q;
	logic [63:0]              sxy64_q;
	logic [PAIR_COUNT_W-1:0]  n_out_q;
	logic                     ovf_q;
	logic                     zero_q;

	logic [127:0]             acc_q;
	logic [63:0]              varx_q;
	logic [63:0]              vary_q;
	logic [63:0]              cov_q;
	logic [67:0]              rem_q;
	logic [63:0]              root_q;
	logic [15:0]              quo_q;

	logic                     result_valid_q;
	logic [CORR_W-1:0]        corr_q;
	logic [PAIR_COUNT_W-1:0]  pair_count_q;
	logic [STATUS_W-1:0]      status_q;

	logic [63:0]              op_a;
	logic [63:0]              op_b;
	logic [31:0]              a_part;
	logic [31:0]              b_part;
	logic [63:0]              pp;
	logic [127:0]             acc_next;
	logic [63:0]              lo;
	logic                     zero_var;
	logic [67:0]              sq_sh;
	logic [67:0]              sq_trial;
	logic                     sq_ge;
	logic [63:0]              mag;
	logic [67:0]              dv_sh;
	logic [67:0]              dv_den;
	logic                     dv_ge;
	logic                     load_out;
	logic [CORR_W-1:0]        corr_next;
	logic [STATUS_W-1:0]      status_next;

	always_comb begin
		unique case (op_q)
			OP_N_SXX: begin
				op_a = n64_q;
				op_b = sxx64_q;
			end
			OP_SX_SX: begin
				op_a = sx64_q;
				op_b = sx64_q;
			end
			OP_N_SYY: begin
				op_a = n64_q;
				op_b = syy64_q;
			end
			OP_SY_SY: begin
				op_a = sy64_q;
				op_b = sy64_q;
			end
			OP_N_SXY: begin
				op_a = n64_q;
				op_b = sxy64_q;
			end
			OP_SX_SY: begin
				op_a = sx64_q;
				op_b = sy64_q;
			end
			default: begin
				op_a = varx_q;
				op_b = vary_q;
			end
		endcase
	end

	assign a_part = step_q[1] ? op_a[63:32] : op_a[31:0];
	assign b_part = step_q[0] ? op_b[63:32] : op_b[31:0];
	assign pp     = a_part * b_part;
	assign lo     = acc_q[63:0];

	always_comb begin
		unique case (step_q)
			STEP_LL: acc_next = {64'd0, pp};
			STEP_LH,
			STEP_HL: acc_next = acc_q + {32'd0, pp, 32'd0};
			STEP_HH: acc_next = acc_q + {pp, 64'd0};
			default: acc_next = acc_q;
		endcase
	end

	assign zero_var = (varx_q == '0) || (vary_q == '0) || varx_q[63] || vary_q[63];

	assign sq_sh    = {rem_q[65:0], acc_q[127:126]};
	assign sq_trial = {2'd0, root_q, 2'b01};
	assign sq_ge    = sq_sh >= sq_trial;

	assign mag    = cov_q[63] ? (64'd0 - cov_q) : cov_q;
	assign dv_sh  = {rem_q[66:0], 1'b0};
	assign dv_den = {4'd0, root_q};
	assign dv_ge  = dv_sh >= dv_den;

	assign q_pop = (state_q == ST_IDLE) && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			op_q      <= OP_N_SXX;
			step_q    <= STEP_LL;
			iter_q    <= '0;
			div_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						op_q    <= OP_N_SXX;
						step_q  <= STEP_LL;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (step_q == STEP_WB) begin
						step_q <= STEP_LL;
						op_q   <= op_q + 3'd1;
						if (op_q == OP_SX_SY && zero_var) begin
							state_q <= ST_DONE;
						end else if (op_q == OP_VAR_PROD) begin
							iter_q  <= '0;
							state_q <= ST_SQRT;
						end
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				ST_SQRT: begin
					iter_q <= iter_q + 6'd1;
					if (iter_q == '1) begin
						div_cnt_q <= '0;
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 4'd1;
					if (div_cnt_q == '0) begin
						if (mag >= root_q) begin
							state_q <= ST_DONE;
						end
					end else if (div_cnt_q == '1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!result_valid_q || !result_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					n64_q   <= 64'(q_data[O_N +: CW]);
					n_out_q <= PAIR_COUNT_W'(q_data[O_N +: CW]);
					ovf_q   <= q_data[O_OVF];
					sx64_q  <= 64'($signed(q_data[O_SX +: SXW]));
					sy64_q  <= 64'($signed(q_data[O_SY +: SXW]));
					sxx64_q <= 64'(q_data[O_SXX +: SQW]);
					syy64_q <= 64'(q_data[O_SYY +: SQW]);
					sxy64_q <= 64'($signed(q_data[O_SXY +: SPW]));
					zero_q  <= 1'b0;
				end
			end
			ST_MUL: begin
				if (step_q == STEP_WB) begin
					unique case (op_q)
						OP_N_SXX: varx_q <= lo;
						OP_SX_SX: varx_q <= varx_q - lo;
						OP_N_SYY: vary_q <= lo;
						OP_SY_SY: vary_q <= vary_q - lo;
						OP_N_SXY: cov_q  <= lo;
						OP_SX_SY: begin
							cov_q <= cov_q - lo;
							if (zero_var) begin
								zero_q <= 1'b1;
								quo_q  <= '0;
							end
						end
						default: begin
							rem_q  <= '0;
							root_q <= '0;
						end
					endcase
				end else begin
					acc_q <= acc_next;
				end
			end
			ST_SQRT: begin
				rem_q  <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
				root_q <= {root_q[62:0], sq_ge};
				acc_q  <= {acc_q[125:0], 2'b00};
			end
			ST_DIV: begin
				if (div_cnt_q == '0) begin
					rem_q <= {4'd0, mag};
					quo_q <= (mag >= root_q) ? QUO_ONE : '0;
				end else begin
					rem_q <= dv_ge ? (dv_sh - dv_den) : dv_sh;
					quo_q <= {quo_q[14:0], dv_ge};
				end
			end
			default: begin
			end
		endcase
	end

	assign load_out = (state_q == ST_DONE) && (!result_valid_q || !result_stall);

	always_comb begin
		if (cov_q[63]) begin
			corr_next = CORR_W'(16'd0 - quo_q);
		end else if (quo_q[15]) begin
			corr_next = CORR_MAX;
		end else begin
			corr_next = quo_q;
		end
		if (ovf_q) begin
			status_next = STATUS_DROPPED;
		end else if (zero_q) begin
			status_next = STATUS_ZERO_VAR;
		end else begin
			status_next = STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_out) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			corr_q       <= zero_q ? '0 : corr_next;
			pair_count_q <= n_out_q;
			status_q     <= status_next;
		end
	end

	assign result_valid = result_valid_q;
	assign corr_q15     = corr_q;
	assign pair_count   = pair_count_q;
	assign status       = status_q;

endmodule

FILE: sv/pearson_correlation_engine.sv
// Channel   Handshake                     Payload
// sample    sample_valid / sample_stall   x_sample, y_sample, last_sample
// result    result_valid / result_stall   corr_q15, pair_count, status
//
// One sample pair is taken per cycle while not stalled; the sums advance in
// a two-stage front. A series end queues its sums; the back forms up to seven
// 64x64 products on one 32x32 multiplier, then 64 square root steps and up
// to 16 quotient steps. Two finished series may wait in the queue.
// Reset clears the sums, the queue and the sequencer; no sweep follows it.
// The sample side stalls only while a series end finds the queue full.
`include "assert_macros.svh"

module pearson_correlation_engine
	import pce_pkg::*;
#(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	parameter int MAX_LEN     = DEF_MAX_LEN
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic signed [SAMPLE_BITS-1:0] x_sample,
	input  logic signed [SAMPLE_BITS-1:0] y_sample,
	input  logic                          last_sample,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	output logic signed [CORR_W-1:0]      corr_q15,
	output logic [PAIR_COUNT_W-1:0]       pair_count,
	output logic [STATUS_W-1:0]           status,
	output logic                          result_valid,
	input  logic                          result_stall
);

	localparam int EW = entry_w(SAMPLE_BITS, MAX_LEN);

	logic          q_push;
	logic [EW-1:0] q_push_data;
	logic          q_pop;
	logic [EW-1:0] q_pop_data;
	logic          q_valid;
	logic          q_full;

	pce_front #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.MAX_LEN    (MAX_LEN),
		.EW         (EW)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.x_sample    (x_sample),
		.y_sample    (y_sample),
		.last_sample (last_sample),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.q_push      (q_push),
		.q_data      (q_push_data),
		.q_full      (q_full)
	);

	pce_fifo #(
		.WIDTH(EW),
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_push_data),
		.pop      (q_pop),
		.pop_data (q_pop_data),
		.not_empty(q_valid),
		.full     (q_full)
	);

	pce_back #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.MAX_LEN    (MAX_LEN),
		.EW         (EW)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_data      (q_pop_data),
		.q_pop       (q_pop),
		.corr_q15    (corr_q15),
		.pair_count  (pair_count),
		.status      (status),
		.result_valid(result_valid),
		.result_stall(result_stall)
	);

	`PCE_ASSERT_ALWAYS(a_push_room, !(q_push && q_full), "series pushed into a full queue")
	`PCE_ASSERT_ALWAYS(a_stall_cause, !sample_stall || q_full, "sample stall without full queue")
	`PCE_ASSERT_ALWAYS(a_pop_data, !(q_pop && !q_valid), "queue popped while empty")
	`PCE_ASSERT_NEXT(a_pop_busy, q_pop, !q_pop, "back popped twice in a row")

endmodule
